[rtl/core/srgblab_pkg.sv]
`default_nettype none
// ============================================================================
// srgblab_pkg
// Shared types, constants and the sRGB linearization table of the sRGB to
// CIE L*a*b* converter.
// ============================================================================
package srgblab_pkg;

    // Fractional bits of a linearized channel.
    localparam int LINEAR_BITS = 16;
    localparam int LIN_W       = LINEAR_BITS + 1;
    localparam int COEF_W      = 14;
    localparam int NUM_W       = LIN_W + COEF_W;
    localparam int RATIO_SH    = 34 - LINEAR_BITS;
    localparam int NUMER_W     = NUM_W + RATIO_SH;
    localparam int RATIO_W     = 31;
    localparam int TOP_W       = NUMER_W - RATIO_W;
    localparam int WHITE_W     = 18;
    localparam int DIV_W       = 25;
    localparam int CFG_IDX_W   = 2;

    // Cube root datapath, Q24.
    localparam int FRAC        = 24;
    localparam int CBRT_W      = 27;
    localparam int SQ_W        = 2 * CBRT_W;
    localparam int CBRT_P_W    = SQ_W - FRAC + CBRT_W;
    localparam int FIT_W       = CBRT_P_W - FRAC;
    localparam int F_W         = CBRT_W;

    // Linear segment of f(): 7q + 2314099 + (2465q + 810) / 3132.
    localparam int LS_Q_W      = 18;
    localparam int LS_X_W      = 29;
    localparam int LS_P_W      = 59;
    localparam int LS_SH       = 41;
    localparam int LINSEG_W    = 24;
    localparam int THR_W       = RATIO_W + 15;

    localparam logic [LS_X_W-1:0]   LS_MUL       = LS_X_W'(2465);
    localparam logic [LS_X_W-1:0]   LS_ADD       = LS_X_W'(810);
    localparam logic [LINSEG_W-1:0] LS_BASE_MUL  = LINSEG_W'(7);
    localparam logic [LINSEG_W-1:0] LS_BASE      = LINSEG_W'(2314099);
    localparam logic [LS_P_W-1:0]   LS_RECIP     = LS_P_W'(702114705);
    localparam logic [THR_W-1:0]    CBRT_THR_MUL = THR_W'(24389);
    localparam logic [THR_W-1:0]    CBRT_THR     = THR_W'(64'd216 << FRAC);

    // Output scaling.
    localparam int LAB_W = 40;
    localparam int OUT_SH = 16;
    localparam logic signed [LAB_W-1:0] L_MUL   = LAB_W'(116);
    localparam logic signed [LAB_W-1:0] L_OFF   = LAB_W'(64'd16 << FRAC);
    localparam logic signed [LAB_W-1:0] A_MUL   = LAB_W'(500);
    localparam logic signed [LAB_W-1:0] B_MUL   = LAB_W'(200);
    localparam logic signed [LAB_W-1:0] OUT_RND = LAB_W'(32768);
    localparam logic signed [LAB_W-1:0] L_MAX   = LAB_W'(32767);
    localparam logic signed [LAB_W-1:0] AB_MAX  = LAB_W'(32767);
    localparam logic signed [LAB_W-1:0] AB_MIN  = -LAB_W'(32768);

    // Reference white, stored as divisor 100 * white.
    localparam logic [WHITE_W-1:0] WHITE_MIN = WHITE_W'(1024);
    localparam logic [DIV_W-1:0]   DIV_MIN   = DIV_W'(102400);
    localparam logic [DIV_W-1:0]   DIV_X_RST = DIV_W'(100 * 97328);
    localparam logic [DIV_W-1:0]   DIV_Y_RST = DIV_W'(100 * 102400);
    localparam logic [DIV_W-1:0]   DIV_Z_RST = DIV_W'(100 * 111496);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_X = 2'd0,
        CFG_WHITE_Y = 2'd1,
        CFG_WHITE_Z = 2'd2
    } cfg_index_t;

    // sRGB to XYZ matrix, coefficients in 1/10000.
    localparam logic [COEF_W-1:0] MTX [3][3] = '{
        '{COEF_W'(4124), COEF_W'(3576), COEF_W'(1805)},
        '{COEF_W'(2126), COEF_W'(7152), COEF_W'(722)},
        '{COEF_W'(193),  COEF_W'(1192), COEF_W'(9505)}
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } lab_t;

    typedef logic [2:0][DIV_W-1:0]   divisor_t;
    typedef logic [2:0][NUMER_W-1:0] numer_t;
    typedef logic [2:0][RATIO_W-1:0] ratio_t;
    typedef logic [2:0][F_W-1:0]     fval_t;
    typedef logic [255:0][LIN_W-1:0] lin_tab_t;

    function automatic logic [DIV_W-1:0] white_div(input logic [WHITE_W-1:0] w);
        logic [WHITE_W-1:0] w_eff;
        w_eff = (w < WHITE_MIN) ? WHITE_MIN : w;
        return DIV_W'(w_eff) * DIV_W'(100);
    endfunction

    // Elaboration-time helpers for the linearization table.
    function automatic longint unsigned pow5_q28(input longint unsigned r);
        longint unsigned p;
        int i;
        p = r;
        for (i = 0; i < 4; i++)
            p = (p * r) >> 28;
        return p;
    endfunction

    function automatic longint unsigned root5_q28(input longint unsigned u);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 28;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (pow5_q28(mid) <= u)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic lin_tab_t build_lin_tab();
        lin_tab_t tab;
        longint unsigned v;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lin28;
        longint unsigned e;
        for (v = 0; v < 256; v++) begin
            if (v * 100000 > 4045 * 255) begin
                t = (((1000 * v + 14025) << 28) + 134512) / 269025;
                t2 = (t * t) >> 28;
                lin28 = (t2 * root5_q28(t2)) >> 28;
            end else begin
                lin28 = (((v * 100) << 28) + 164730) / 329460;
            end
            e = (lin28 + (64'd1 << (27 - LINEAR_BITS))) >> (28 - LINEAR_BITS);
            tab[v] = LIN_W'(e);
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage
`default_nettype wire

[rtl/core/srgblab_xyz.sv]
`default_nettype none
// ============================================================================
// srgblab_xyz
// Linearizes the three channels, applies the XYZ matrix and forms the
// rounded dividend for the white point division. Four stages.
// ============================================================================
module srgblab_xyz (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  srgblab_pkg::pixel_t    pixel,
    input  srgblab_pkg::divisor_t  divisor,
    output logic                   valid_out,
    output srgblab_pkg::numer_t    numer
);
    import srgblab_pkg::*;

    logic [3:0]                   valid_reg;
    logic [LIN_W-1:0]             lin_reg [3];
    logic [NUM_W-1:0]             prod_reg [3][3];
    logic [NUM_W-1:0]             sum_reg [3];
    numer_t                       numer_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], valid_in};
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            lin_reg[0] <= LIN_TAB[pixel.red];
            lin_reg[1] <= LIN_TAB[pixel.green];
            lin_reg[2] <= LIN_TAB[pixel.blue];
        end
    end

    for (genvar row = 0; row < 3; row++) begin : g_row
        for (genvar col = 0; col < 3; col++) begin : g_col
            always_ff @(posedge clk) begin
                if (en)
                    prod_reg[row][col] <= NUM_W'(lin_reg[col]) * NUM_W'(MTX[row][col]);
            end
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                sum_reg[row] <= prod_reg[row][0] + prod_reg[row][1] + prod_reg[row][2];
                // scale up and add half the divisor for round-half-up
                numer_reg[row] <= (NUMER_W'(sum_reg[row]) << RATIO_SH)
                                + NUMER_W'(divisor[row][DIV_W-1:1]);
            end
        end
    end

    assign valid_out = valid_reg[3];
    assign numer     = numer_reg;

endmodule
`default_nettype wire

[rtl/core/srgblab_div.sv]
`default_nettype none
// ============================================================================
// srgblab_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ============================================================================
module srgblab_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  srgblab_pkg::numer_t    numer,
    input  srgblab_pkg::divisor_t  divisor,
    output logic                   valid_out,
    output srgblab_pkg::ratio_t    ratio
);
    import srgblab_pkg::*;

    logic [RATIO_W-1:0] valid_reg;
    logic [DIV_W-1:0]   rem_reg [RATIO_W-1][3];
    logic [RATIO_W-1:0] pq_reg  [RATIO_W][3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[RATIO_W-2:0], valid_in};
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        for (genvar i = 0; i < RATIO_W; i++) begin : g_step
            logic [DIV_W-1:0]   rem_src;
            logic [RATIO_W-1:0] pq_src;
            logic [DIV_W:0]     trial;
            logic               fit;

            if (i == 0) begin : g_first
                // top bits are below the divisor since the quotient fits
                assign rem_src = DIV_W'(numer[c][NUMER_W-1:RATIO_W]);
                assign pq_src  = numer[c][RATIO_W-1:0];
            end else begin : g_next
                assign rem_src = rem_reg[i-1][c];
                assign pq_src  = pq_reg[i-1][c];
            end

            assign trial = {rem_src, pq_src[RATIO_W-1]};
            assign fit   = trial >= {1'b0, divisor[c]};

            always_ff @(posedge clk) begin
                if (en)
                    pq_reg[i][c] <= {pq_src[RATIO_W-2:0], fit};
            end

            if (i < RATIO_W - 1) begin : g_rem
                always_ff @(posedge clk) begin
                    if (en)
                        rem_reg[i][c] <= fit ? DIV_W'(trial - {1'b0, divisor[c]})
                                             : trial[DIV_W-1:0];
                end
            end
        end

        assign ratio[c] = pq_reg[RATIO_W-1][c];
    end

    assign valid_out = valid_reg[RATIO_W-1];

endmodule
`default_nettype wire

[rtl/core/srgblab_cief.sv]
`default_nettype none
// ============================================================================
// srgblab_cief
// CIE f(): linear segment in three stages, then a bit-per-two-stages cube
// root with an incrementally kept square, three lanes.
// ============================================================================
module srgblab_cief (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  srgblab_pkg::ratio_t  ratio,
    output logic                 valid_out,
    output srgblab_pkg::fval_t   fval
);
    import srgblab_pkg::*;

    localparam int LAT = 3 + 2 * CBRT_W;

    logic [LAT-1:0]      valid_reg;

    logic [RATIO_W-1:0]  p1_q_reg [3];
    logic [LS_X_W-1:0]   p1_x_reg [3];
    logic [LINSEG_W-1:0] p1_base_reg [3];
    logic                p1_sel_reg [3];
    logic [RATIO_W-1:0]  p2_q_reg [3];
    logic [LS_P_W-1:0]   p2_prod_reg [3];
    logic [LINSEG_W-1:0] p2_base_reg [3];
    logic                p2_sel_reg [3];
    logic [RATIO_W-1:0]  p3_q_reg [3];
    logic [LINSEG_W-1:0] p3_lin_reg [3];
    logic                p3_sel_reg [3];

    logic [CBRT_W-1:0]   a_cr_reg  [CBRT_W][3];
    logic [SQ_W-1:0]     a_cs_reg  [CBRT_W][3];
    logic [SQ_W-1:0]     a_s_reg   [CBRT_W-1][3];
    logic [RATIO_W-1:0]  a_q_reg   [CBRT_W][3];
    logic [LINSEG_W-1:0] a_lin_reg [CBRT_W][3];
    logic                a_sel_reg [CBRT_W][3];

    logic [CBRT_W-1:0]   b_r_reg   [CBRT_W][3];
    logic [SQ_W-1:0]     b_s_reg   [CBRT_W-1][3];
    logic [RATIO_W-1:0]  b_q_reg   [CBRT_W-1][3];
    logic [LINSEG_W-1:0] b_lin_reg [CBRT_W][3];
    logic                b_sel_reg [CBRT_W][3];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], valid_in};
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        always_ff @(posedge clk) begin
            if (en)
            begin
                p1_q_reg[c]    <= ratio[c];
                p1_x_reg[c]    <= LS_X_W'(ratio[c][LS_Q_W-1:0]) * LS_MUL + LS_ADD;
                p1_base_reg[c] <= LINSEG_W'(ratio[c]) * LS_BASE_MUL + LS_BASE;
                p1_sel_reg[c]  <= (THR_W'(ratio[c]) * CBRT_THR_MUL) > CBRT_THR;

                p2_q_reg[c]    <= p1_q_reg[c];
                p2_prod_reg[c] <= LS_P_W'(p1_x_reg[c]) * LS_RECIP;
                p2_base_reg[c] <= p1_base_reg[c];
                p2_sel_reg[c]  <= p1_sel_reg[c];

                p3_q_reg[c]    <= p2_q_reg[c];
                p3_lin_reg[c]  <= p2_base_reg[c]
                                + LINSEG_W'(p2_prod_reg[c][LS_P_W-1:LS_SH]);
                p3_sel_reg[c]  <= p2_sel_reg[c];
            end
        end

        for (genvar j = 0; j < CBRT_W; j++) begin : g_bit
            localparam int K = CBRT_W - 1 - j;
            logic [CBRT_W-1:0]   r_src;
            logic [SQ_W-1:0]     s_src;
            logic [RATIO_W-1:0]  q_src;
            logic [LINSEG_W-1:0] lin_src;
            logic                sel_src;
            logic [CBRT_P_W-1:0] cube;
            logic                fit;

            if (j == 0) begin : g_first
                assign r_src   = '0;
                assign s_src   = '0;
                assign q_src   = p3_q_reg[c];
                assign lin_src = p3_lin_reg[c];
                assign sel_src = p3_sel_reg[c];
            end else begin : g_next
                assign r_src   = b_r_reg[j-1][c];
                assign s_src   = b_s_reg[j-1][c];
                assign q_src   = b_q_reg[j-1][c];
                assign lin_src = b_lin_reg[j-1][c];
                assign sel_src = b_sel_reg[j-1][c];
            end

            // trial bit and its square: (r + 2^k)^2 = r^2 + r*2^(k+1) + 2^(2k)
            always_ff @(posedge clk) begin
                if (en)
                begin
                    a_cr_reg[j][c]  <= r_src | (CBRT_W'(1) << K);
                    a_cs_reg[j][c]  <= s_src + (SQ_W'(r_src) << (K + 1))
                                     + (SQ_W'(1) << (2 * K));
                    a_q_reg[j][c]   <= q_src;
                    a_lin_reg[j][c] <= lin_src;
                    a_sel_reg[j][c] <= sel_src;
                end
            end

            assign cube = CBRT_P_W'(a_cs_reg[j][c][SQ_W-1:FRAC]) * CBRT_P_W'(a_cr_reg[j][c]);
            assign fit  = cube[CBRT_P_W-1:FRAC] <= FIT_W'(a_q_reg[j][c]);

            // keep the trial bit when the truncated cube stays within q
            always_ff @(posedge clk) begin
                if (en)
                begin
                    b_r_reg[j][c]   <= fit ? a_cr_reg[j][c]
                                           : (a_cr_reg[j][c] & ~(CBRT_W'(1) << K));
                    b_lin_reg[j][c] <= a_lin_reg[j][c];
                    b_sel_reg[j][c] <= a_sel_reg[j][c];
                end
            end

            if (j < CBRT_W - 1) begin : g_carry
                always_ff @(posedge clk) begin
                    if (en)
                    begin
                        a_s_reg[j][c] <= s_src;
                        b_s_reg[j][c] <= fit ? a_cs_reg[j][c] : a_s_reg[j][c];
                        b_q_reg[j][c] <= a_q_reg[j][c];
                    end
                end
            end
        end

        assign fval[c] = b_sel_reg[CBRT_W-1][c] ? b_r_reg[CBRT_W-1][c]
                                                : F_W'(b_lin_reg[CBRT_W-1][c]);
    end

    assign valid_out = valid_reg[LAT-1];

endmodule
`default_nettype wire

[rtl/core/srgblab_lab.sv]
`default_nettype none
// ============================================================================
// srgblab_lab
// Forms L*, a*, b* from f(X), f(Y), f(Z), rounds to 1/256 and saturates.
// ============================================================================
module srgblab_lab (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  srgblab_pkg::fval_t   fval,
    output logic                 valid_out,
    output srgblab_pkg::lab_t    lab
);
    import srgblab_pkg::*;

    logic [1:0]              valid_reg;
    logic signed [LAB_W-1:0] fx;
    logic signed [LAB_W-1:0] fy;
    logic signed [LAB_W-1:0] fz;
    logic signed [LAB_W-1:0] l_reg;
    logic signed [LAB_W-1:0] a_reg;
    logic signed [LAB_W-1:0] b_reg;
    logic signed [LAB_W-1:0] l_sh;
    logic signed [LAB_W-1:0] a_sh;
    logic signed [LAB_W-1:0] b_sh;
    lab_t                    lab_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[0], valid_in};
    end

    assign fx = $signed(LAB_W'(fval[0]));
    assign fy = $signed(LAB_W'(fval[1]));
    assign fz = $signed(LAB_W'(fval[2]));

    always_ff @(posedge clk) begin
        if (en)
        begin
            l_reg <= fy * L_MUL - L_OFF;
            a_reg <= (fx - fy) * A_MUL;
            b_reg <= (fy - fz) * B_MUL;
        end
    end

    // round half up, floor toward minus infinity
    assign l_sh = (l_reg + OUT_RND) >>> OUT_SH;
    assign a_sh = (a_reg + OUT_RND) >>> OUT_SH;
    assign b_sh = (b_reg + OUT_RND) >>> OUT_SH;

    always_ff @(posedge clk) begin
        if (en)
        begin
            if (l_sh < 0)
                lab_reg.lightness <= '0;
            else if (l_sh > L_MAX)
                lab_reg.lightness <= 15'h7FFF;
            else
                lab_reg.lightness <= l_sh[14:0];

            if (a_sh > AB_MAX)
                lab_reg.green_red <= 16'sh7FFF;
            else if (a_sh < AB_MIN)
                lab_reg.green_red <= 16'sh8000;
            else
                lab_reg.green_red <= a_sh[15:0];

            if (b_sh > AB_MAX)
                lab_reg.blue_yellow <= 16'sh7FFF;
            else if (b_sh < AB_MIN)
                lab_reg.blue_yellow <= 16'sh8000;
            else
                lab_reg.blue_yellow <= b_sh[15:0];
        end
    end

    assign valid_out = valid_reg[1];
    assign lab       = lab_reg;

endmodule
`default_nettype wire

[rtl/core/srgb_to_cielab.sv]
`default_nettype none
// ============================================================================
// srgb_to_cielab
// Streaming sRGB to CIE L*a*b* converter, one pixel per clock unless stalled.
// ============================================================================
// The block takes one pixel per clock while pixel_stall is low and returns one
// L*a*b* transaction per pixel, in order. On the way to the output register a
// pixel passes 4 stages of table lookup and matrix, 31 stages of the
// restoring divider by the reference white (one quotient bit per stage),
// 3 stages of the linear f() segment, 54 stages of the cube root (27 result
// bits, two stages per bit), 2 stages of scaling and saturation, and the
// output register. Every stage advances together; a skid register behind
// the output holds one extra transaction, so the input keeps flowing while
// a finished result waits, and only when the skid register is full does the
// pipeline hold and pixel_stall rise. Reference white registers are written
// through cfg_wen/cfg_index/cfg_data (index 0 X, 1 Y, 2 Z, units of 1/1024;
// values below 1024 act as 1024, other indexes are dropped) and must be
// written only while no pixel is in flight.
// ============================================================================
module srgb_to_cielab (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  srgblab_pkg::pixel_t                  pixel,
    output logic                                 lab_valid,
    input  logic                                 lab_stall,
    output srgblab_pkg::lab_t                    lab,
    input  logic                                 cfg_wen,
    input  logic [srgblab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srgblab_pkg::WHITE_W-1:0]      cfg_data
);
    import srgblab_pkg::*;

    // Divisors 100 * white, kept ready for the divider stages.
    divisor_t d_reg;

    logic     en;
    logic     xyz_valid;
    numer_t   numer;
    logic     div_valid;
    ratio_t   ratio;
    logic     cief_valid;
    fval_t    fval;
    logic     pipe_valid;
    lab_t     pipe_lab;

    logic     lab_valid_reg;
    lab_t     lab_reg;
    logic     skid_valid_reg;
    lab_t     skid_reg;
    logic     out_take;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            d_reg[0] <= DIV_X_RST;
            d_reg[1] <= DIV_Y_RST;
            d_reg[2] <= DIV_Z_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_WHITE_X: d_reg[0] <= white_div(cfg_data);
                CFG_WHITE_Y: d_reg[1] <= white_div(cfg_data);
                CFG_WHITE_Z: d_reg[2] <= white_div(cfg_data);
                default:     ;
            endcase
        end
    end

    // Hold the whole pipeline only while the skid register is occupied.
    assign en          = !skid_valid_reg;
    assign pixel_stall = skid_valid_reg;

    srgblab_xyz u_xyz (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pixel_valid),
        .pixel     (pixel),
        .divisor   (d_reg),
        .valid_out (xyz_valid),
        .numer     (numer)
    );

    srgblab_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (xyz_valid),
        .numer     (numer),
        .divisor   (d_reg),
        .valid_out (div_valid),
        .ratio     (ratio)
    );

    srgblab_cief u_cief (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (div_valid),
        .ratio     (ratio),
        .valid_out (cief_valid),
        .fval      (fval)
    );

    srgblab_lab u_lab (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (cief_valid),
        .fval      (fval),
        .valid_out (pipe_valid),
        .lab       (pipe_lab)
    );

    // Output register with skid: a transaction leaving the pipeline while the
    // output is held parks in the skid register instead of being lost.
    assign out_take = lab_valid_reg && !lab_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            lab_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                lab_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!lab_valid_reg || out_take)
        begin
            lab_valid_reg <= pipe_valid;
        end
        else if (pipe_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (skid_valid_reg)
        begin
            if (out_take)
                lab_reg <= skid_reg;
        end
        else if (!lab_valid_reg || out_take)
        begin
            lab_reg <= pipe_lab;
        end
        else if (pipe_valid)
        begin
            skid_reg <= pipe_lab;
        end
    end

    assign lab_valid = lab_valid_reg;
    assign lab       = lab_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> lab_valid_reg)
        else $error("skid register holds data while output is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (lab_valid_reg && lab_stall && !skid_valid_reg && pipe_valid) |=> skid_valid_reg)
        else $error("pipeline result dropped while output was held");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !lab_stall) |=> (lab_valid_reg && !skid_valid_reg))
        else $error("skid register did not move to output");

    a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (d_reg[0] >= DIV_MIN) && (d_reg[1] >= DIV_MIN) && (d_reg[2] >= DIV_MIN))
        else $error("reference white divisor below minimum");
`endif

endmodule
`default_nettype wire
